FILE: src/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: script push tokenizer types and constants
// opcode codes, byte roles and walker phases shared by the tokenizer files
// ----------------------------------------------------------------------------
package spt_pkg;

	// opcode values
	localparam logic [7:0] MAX_DIRECT_PUSH = 8'h4B;
	localparam logic [7:0] OPC_PUSHDATA1   = 8'h4C;
	localparam logic [7:0] OPC_PUSHDATA2   = 8'h4D;
	localparam logic [7:0] OPC_PUSHDATA4   = 8'h4E;

	// byte role codes on the result channel
	typedef logic [1:0] role_t;
	localparam role_t ROLE_OPCODE = 2'd0;
	localparam role_t ROLE_LENGTH = 2'd1;
	localparam role_t ROLE_DATA   = 2'd2;

	// walker phase
	typedef enum logic [1:0] {
		PH_OPCODE = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

endpackage

FILE: src/spt_if.sv
// ----------------------------------------------------------------------------
// spt_if: script byte and result channels
// valid/ready channels for the script push tokenizer
// ----------------------------------------------------------------------------
interface spt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] script_byte;
	logic       last_byte;

	modport source (output valid, output script_byte, output last_byte, input ready);
	modport sink (input valid, input script_byte, input last_byte, output ready);
endinterface

interface spt_result_if;
	logic              valid;
	logic              ready;
	spt_pkg::role_t    byte_role;
	logic              script_done;
	logic              script_valid;

	modport source (output valid, output byte_role, output script_done,
		output script_valid, input ready);
	modport sink (input valid, input byte_role, input script_done,
		input script_valid, output ready);
endinterface

FILE: src/script_push_tokenizer.sv
// ----------------------------------------------------------------------------
// script_push_tokenizer: transaction script push structure walker
// tags each script byte as opcode, push length or push data and flags
// truncated pushes at the end of a script
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  script    in   valid/ready    script_byte[7:0], last_byte
//  result    out  valid/ready    byte_role[1:0], script_done, script_valid
//  cfg       in   length_big_endian_we   length_big_endian_wdata
//
//  one byte per cycle while the result is not stalled; the walker state and
//  the result register are both updated at the edge that accepts a byte
//  a byte is taken while the result register is empty or being drained
//  reset clears the walker to expecting opcode and sets big-endian lengths
//  a stalled result holds its register and backs up the script channel
// ----------------------------------------------------------------------------
module script_push_tokenizer (
	input  logic clk,
	input  logic arst_n,
	spt_byte_if.sink     script,
	spt_result_if.source result,
	input  logic length_big_endian_we,
	input  logic length_big_endian_wdata
);
	import spt_pkg::*;

	// config register
	logic big_endian_q;

	// walker state
	phase_t      phase_q;
	logic [2:0]  len_left_q;
	logic [31:0] accum_q;
	logic [1:0]  len_idx_q;
	logic [31:0] data_left_q;

	// result register
	logic  res_valid_q;
	role_t role_q;
	logic  done_q;
	logic  ok_q;

	// next state
	phase_t      phase_d;
	logic [2:0]  len_left_d;
	logic [31:0] accum_d;
	logic [1:0]  len_idx_d;
	logic [31:0] data_left_d;
	role_t       role_d;
	logic        ok_d;
	logic        accept;

	// take a byte whenever the result slot is free or emptying this cycle
	assign script.ready = !res_valid_q || result.ready;
	assign accept       = script.valid && script.ready;

	always_comb begin
		phase_d     = phase_q;
		len_left_d  = len_left_q;
		accum_d     = accum_q;
		len_idx_d   = len_idx_q;
		data_left_d = data_left_q;
		role_d      = ROLE_OPCODE;
		case (phase_q)
			PH_LENGTH: begin
				role_d = ROLE_LENGTH;
				if (big_endian_q) begin
					accum_d = {accum_q[23:0], script.script_byte};
				end else begin
					case (len_idx_q)
						2'd0: accum_d[7:0]   = accum_q[7:0]   | script.script_byte;
						2'd1: accum_d[15:8]  = accum_q[15:8]  | script.script_byte;
						2'd2: accum_d[23:16] = accum_q[23:16] | script.script_byte;
						default: accum_d[31:24] = accum_q[31:24] | script.script_byte;
					endcase
				end
				len_idx_d  = len_idx_q + 2'd1;
				len_left_d = len_left_q - 3'd1;
				// length field complete: zero length means no data follows
				if (len_left_d == 3'd0) begin
					if (accum_d == 32'd0) begin
						phase_d = PH_OPCODE;
					end else begin
						data_left_d = accum_d;
						phase_d     = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				role_d      = ROLE_DATA;
				data_left_d = data_left_q - 32'd1;
				if (data_left_d == 32'd0) begin
					phase_d = PH_OPCODE;
				end
			end
			default: begin
				// opcode byte; unused phase code falls here too
				role_d = ROLE_OPCODE;
				if (script.script_byte >= 8'd1 && script.script_byte <= MAX_DIRECT_PUSH) begin
					data_left_d = 32'(script.script_byte);
					phase_d     = PH_DATA;
				end else if (script.script_byte == OPC_PUSHDATA1 ||
						script.script_byte == OPC_PUSHDATA2 ||
						script.script_byte == OPC_PUSHDATA4) begin
					if (script.script_byte == OPC_PUSHDATA1) begin
						len_left_d = 3'd1;
					end else if (script.script_byte == OPC_PUSHDATA2) begin
						len_left_d = 3'd2;
					end else begin
						len_left_d = 3'd4;
					end
					accum_d   = 32'd0;
					len_idx_d = 2'd0;
					phase_d   = PH_LENGTH;
				end else begin
					phase_d = PH_OPCODE;
				end
			end
		endcase
		// end of script: judge, then start the next script from scratch
		ok_d = 1'b0;
		if (script.last_byte) begin
			ok_d        = (phase_d == PH_OPCODE);
			phase_d     = PH_OPCODE;
			len_left_d  = 3'd0;
			accum_d     = 32'd0;
			len_idx_d   = 2'd0;
			data_left_d = 32'd0;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (length_big_endian_we) begin
			big_endian_q <= length_big_endian_wdata;
		end
	end

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPCODE;
			len_left_q  <= 3'd0;
			accum_q     <= 32'd0;
			len_idx_q   <= 2'd0;
			data_left_q <= 32'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			len_left_q  <= len_left_d;
			accum_q     <= accum_d;
			len_idx_q   <= len_idx_d;
			data_left_q <= data_left_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			role_q <= role_d;
			done_q <= script.last_byte;
			ok_q   <= ok_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.byte_role    = role_q;
	assign result.script_done  = done_q;
	assign result.script_valid = ok_q;

	// a length field always has bytes owed while in progress
	a_len_pending: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LENGTH |-> len_left_q != 3'd0)
		else $error("length phase with no length bytes owed");

	// a push in progress always has data owed
	a_data_pending: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> data_left_q != 32'd0)
		else $error("data phase with no data bytes owed");

	// the byte after a script end is parsed as an opcode
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && script.last_byte |=> phase_q == PH_OPCODE && len_idx_q == 2'd0)
		else $error("walker not reset after last byte");

	// a verdict only comes with a script end
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && ok_q |-> done_q)
		else $error("script_valid without script_done");

endmodule
